/* design/inverse_permutation_domain_presolve_top_macros.svh */
// assertion macros for the inverse permutation domain presolver
// no dependencies; included by the files that carry assertions
`ifndef INVERSE_PERMUTATION_DOMAIN_PRESOLVE_TOP_MACROS_SVH
`define INVERSE_PERMUTATION_DOMAIN_PRESOLVE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// plain property check, disabled while reset is asserted
`define IPDP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// overlapping implication check
`define IPDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define IPDP_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/ipdp_pkg.sv */
// shared types, constants and helper functions of the domain presolver
// no dependencies
package ipdp_pkg;

  localparam int MaxVars    = 16;
  localparam int ValueBits  = 16;
  localparam int StoreDepth = 2 * MaxVars;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int LoadW      = $clog2(StoreDepth + 1);
  localparam int VarW       = $clog2(MaxVars + 1);
  localparam int VarIdxW    = $clog2(MaxVars);
  localparam int ValIdxW    = $clog2(ValueBits);
  localparam int CfgW       = 5;
  localparam int StatusW    = 2;
  localparam int LimN       = (MaxVars < ValueBits) ? MaxVars : ValueBits;

  localparam logic [StatusW-1:0] StatUnchanged = 2'd0;
  localparam logic [StatusW-1:0] StatChanged   = 2'd1;
  localparam logic [StatusW-1:0] StatContra    = 2'd2;

  typedef struct packed {
    logic [ValueBits-1:0] domain_bits;
    logic                 outside_values;
    logic                 last_domain;
  } ipdp_in_t;

  typedef struct packed {
    logic [ValueBits-1:0] pruned_bits;
    logic [StatusW-1:0]   status;
    logic                 last_result;
  } ipdp_out_t;

  typedef struct packed {
    logic                 en;
    logic [AddrW-1:0]     addr;
    logic [ValueBits-1:0] data;
  } ipdp_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MASK_RD,
    ST_MASK_CHK,
    ST_FX_FRD,
    ST_FX_FCHK,
    ST_FX_GRD,
    ST_FX_GCHK,
    ST_FX_TCHK,
    ST_SP_RD,
    ST_SP_CHK,
    ST_SP_VCHK,
    ST_SP_WR,
    ST_OUT_RD,
    ST_OUT_EMIT,
    ST_CONTRA
  } ipdp_state_e;

  function automatic logic is_single(logic [ValueBits-1:0] d);
    return (d != '0) && ((d & (d - ValueBits'(1))) == '0);
  endfunction

  // one-hot to index, only meaningful for a single-bit value
  function automatic logic [ValIdxW-1:0] bit_index(logic [ValueBits-1:0] d);
    logic [ValIdxW-1:0] idx;
    idx = '0;
    for (int b = 0; b < ValueBits; b++) begin
      if (d[b]) begin
        idx = idx | ValIdxW'(b);
      end
    end
    return idx;
  endfunction

  function automatic logic [ValueBits-1:0] mask_of(logic [VarW-1:0] n);
    logic [ValueBits-1:0] m;
    m = '0;
    for (int b = 0; b < ValueBits; b++) begin
      m[b] = (int'(n) > b);
    end
    return m;
  endfunction

  // clamp the count register to 1..min(MaxVars, ValueBits)
  function automatic logic [VarW-1:0] active_n(logic [CfgW-1:0] c);
    logic [VarW-1:0] n;
    if (c == '0) begin
      n = VarW'(1);
    end else if (int'(c) > LimN) begin
      n = VarW'(LimN);
    end else begin
      n = VarW'(c);
    end
    return n;
  endfunction

endpackage

/* design/ipdp_store.sv */
// domain store: one write port, one registered read port
// depends on ipdp_pkg
module ipdp_store (
  input  logic                          clk_i,
  input  ipdp_pkg::ipdp_wr_t            wr_i,
  input  logic [ipdp_pkg::AddrW-1:0]    rd_addr_i,
  output logic [ipdp_pkg::ValueBits-1:0] rd_data_o
);
  import ipdp_pkg::*;

  logic [ValueBits-1:0] mem_q [StoreDepth];
  logic [ValueBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/inverse_permutation_domain_presolve_top.sv */
// inverse permutation domain presolver: loads 2n domains one per cycle while idle, then
// narrows them under f[i]=j <=> g[j]=i in a loop over the store.
// after last_domain the run masks every domain, then repeats passes of fixing and
// support pruning while a pass changes a domain, then emits the results.
// busy stays high for the whole run; one store read per cycle sets the pace.
// async active-low reset clears control state and sets the count register to 16.
`include "inverse_permutation_domain_presolve_top_macros.svh"

module inverse_permutation_domain_presolve_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command-style input
  input  logic                        start_i,
  output logic                        busy_o,
  input  ipdp_pkg::ipdp_in_t          item_i,
  // result strobe, cannot be held off
  output logic                        result_valid_o,
  output ipdp_pkg::ipdp_out_t         result_o,
  // count register write
  input  logic                        cfg_we_i,
  input  logic [ipdp_pkg::CfgW-1:0]   cfg_wdata_i
);
  import ipdp_pkg::*;

  // sequencer and control registers
  ipdp_state_e          state_q, state_d;
  logic [LoadW-1:0]     load_cnt_q, load_cnt_d;
  logic                 changed_q, changed_d;
  logic                 progress_q, progress_d;
  logic [VarW-1:0]      n_q, n_d;
  logic [CfgW-1:0]      cfg_q;
  logic [AddrW-1:0]     k_q, k_d;
  logic [VarIdxW-1:0]   i_q, i_d;
  logic [VarIdxW-1:0]   v_q, v_d;
  logic                 fix_side_q, fix_side_d;
  logic                 sup_side_q, sup_side_d;
  logic                 res_vld_q, res_vld_d;

  // payload registers
  logic [ValueBits-1:0] mask_q, mask_d;
  logic [ValueBits-1:0] d_q, d_d;
  logic [ValueBits-1:0] keep_q, keep_d;
  logic [AddrW-1:0]     tgt_q, tgt_d;
  ipdp_out_t            res_q, res_d;

  // store interface
  ipdp_wr_t             wr;
  logic [AddrW-1:0]     rd_addr;
  logic [ValueBits-1:0] rd_data;

  // shared compare and select logic
  logic [VarW-1:0]      n_act;
  logic                 accept;
  logic                 load_ok;
  logic [AddrW-1:0]     two_n_m1;
  logic                 i_last, v_last, k_last;
  logic [AddrW-1:0]     own_base, other_base;
  logic                 rd_single;
  logic [ValIdxW-1:0]   rd_bidx;
  logic [ValueBits-1:0] one_v, bit_i, bit_v;
  logic                 fix_bad, fix_write;
  logic [ValueBits-1:0] masked;
  logic                 mask_bad, mask_drop;
  logic                 keep_hit;
  logic                 sup_chg, sup_bad;
  logic                 prog_now;

  ipdp_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign n_act      = active_n(cfg_q);
  assign accept     = start_i && (state_q == ST_IDLE);
  assign load_ok    = (load_cnt_q < (LoadW'(n_act) << 1)) &&
                      (load_cnt_q < LoadW'(StoreDepth));
  assign two_n_m1   = AddrW'((LoadW'(n_q) << 1) - LoadW'(1));
  assign i_last     = (i_q == VarIdxW'(n_q - VarW'(1)));
  assign v_last     = (v_q == VarIdxW'(n_q - VarW'(1)));
  assign k_last     = (k_q == two_n_m1);
  assign own_base   = sup_side_q ? AddrW'(n_q) : '0;
  assign other_base = sup_side_q ? '0 : AddrW'(n_q);

  assign rd_single  = is_single(rd_data);
  assign rd_bidx    = bit_index(rd_data);
  assign one_v      = ValueBits'(1);
  assign bit_i      = one_v << ValIdxW'(i_q);
  assign bit_v      = one_v << ValIdxW'(v_q);

  // fixing a target to value i: a clash or a missing value is a contradiction
  assign fix_bad    = rd_single ? (rd_data != bit_i) : ((rd_data & bit_i) == '0);
  assign fix_write  = !rd_single && ((rd_data & bit_i) != '0);

  assign masked     = rd_data & mask_q;
  assign mask_bad   = (masked == '0);
  assign mask_drop  = ((rd_data & ~mask_q) != '0);

  // value v of own row i survives if other row v still holds i
  assign keep_hit   = d_q[ValIdxW'(v_q)] && rd_data[ValIdxW'(i_q)];
  assign sup_chg    = (keep_q != d_q);
  assign sup_bad    = (keep_q == '0);
  assign prog_now   = progress_q || ((state_q == ST_SP_WR) && sup_chg);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_i.last_domain) begin
          state_d = ST_MASK_RD;
        end
      end
      ST_MASK_RD: begin
        state_d = ST_MASK_CHK;
      end
      ST_MASK_CHK: begin
        if (mask_bad) begin
          state_d = ST_CONTRA;
        end else if (k_last) begin
          state_d = ST_FX_FRD;
        end else begin
          state_d = ST_MASK_RD;
        end
      end
      ST_FX_FRD: begin
        state_d = ST_FX_FCHK;
      end
      ST_FX_FCHK: begin
        state_d = rd_single ? ST_FX_TCHK : ST_FX_GRD;
      end
      ST_FX_GRD: begin
        state_d = ST_FX_GCHK;
      end
      ST_FX_GCHK: begin
        if (rd_single) begin
          state_d = ST_FX_TCHK;
        end else begin
          state_d = i_last ? ST_SP_RD : ST_FX_FRD;
        end
      end
      ST_FX_TCHK: begin
        if (fix_bad) begin
          state_d = ST_CONTRA;
        end else if (!fix_side_q) begin
          state_d = ST_FX_GRD;
        end else begin
          state_d = i_last ? ST_SP_RD : ST_FX_FRD;
        end
      end
      ST_SP_RD: begin
        state_d = ST_SP_CHK;
      end
      ST_SP_CHK: begin
        if (!rd_single) begin
          state_d = ST_SP_VCHK;
        end else if (!i_last) begin
          state_d = ST_SP_RD;
        end else if (!sup_side_q) begin
          state_d = ST_SP_RD;
        end else begin
          state_d = prog_now ? ST_FX_FRD : ST_OUT_RD;
        end
      end
      ST_SP_VCHK: begin
        if (v_last) begin
          state_d = ST_SP_WR;
        end
      end
      ST_SP_WR: begin
        if (sup_bad) begin
          state_d = ST_CONTRA;
        end else if (!i_last) begin
          state_d = ST_SP_RD;
        end else if (!sup_side_q) begin
          state_d = ST_SP_RD;
        end else begin
          state_d = prog_now ? ST_FX_FRD : ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (k_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CONTRA: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath, store control and result
  always_comb begin
    load_cnt_d = load_cnt_q;
    changed_d  = changed_q;
    progress_d = progress_q;
    n_d        = n_q;
    mask_d     = mask_q;
    k_d        = k_q;
    i_d        = i_q;
    v_d        = v_q;
    fix_side_d = fix_side_q;
    sup_side_d = sup_side_q;
    d_d        = d_q;
    keep_d     = keep_q;
    tgt_d      = tgt_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    wr         = '0;
    rd_addr    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (load_ok) begin
            wr.en      = 1'b1;
            wr.addr    = AddrW'(load_cnt_q);
            wr.data    = item_i.domain_bits;
            load_cnt_d = load_cnt_q + LoadW'(1);
            if (item_i.outside_values) begin
              changed_d = 1'b1;
            end
          end
          if (item_i.last_domain) begin
            n_d    = n_act;
            mask_d = mask_of(n_act);
            k_d    = '0;
          end
        end
      end
      ST_MASK_RD: begin
        rd_addr = k_q;
      end
      ST_MASK_CHK: begin
        // drop values n and above, empty domain ends the run
        wr.en   = 1'b1;
        wr.addr = k_q;
        wr.data = masked;
        if (mask_drop) begin
          changed_d = 1'b1;
        end
        k_d = k_q + AddrW'(1);
        if (k_last) begin
          i_d        = '0;
          progress_d = 1'b0;
        end
      end
      ST_FX_FRD: begin
        rd_addr = AddrW'(i_q);
      end
      ST_FX_FCHK: begin
        // forward i fixed to j: look up inverse j
        if (rd_single) begin
          rd_addr    = AddrW'(n_q) + AddrW'(rd_bidx);
          tgt_d      = AddrW'(n_q) + AddrW'(rd_bidx);
          fix_side_d = 1'b0;
        end
      end
      ST_FX_GRD: begin
        rd_addr = AddrW'(n_q) + AddrW'(i_q);
      end
      ST_FX_GCHK: begin
        if (rd_single) begin
          rd_addr    = AddrW'(rd_bidx);
          tgt_d      = AddrW'(rd_bidx);
          fix_side_d = 1'b1;
        end else if (i_last) begin
          i_d        = '0;
          sup_side_d = 1'b0;
        end else begin
          i_d = i_q + VarIdxW'(1);
        end
      end
      ST_FX_TCHK: begin
        if (fix_write) begin
          wr.en      = 1'b1;
          wr.addr    = tgt_q;
          wr.data    = bit_i;
          changed_d  = 1'b1;
          progress_d = 1'b1;
        end
        if (fix_side_q && !fix_bad) begin
          if (i_last) begin
            i_d        = '0;
            sup_side_d = 1'b0;
          end else begin
            i_d = i_q + VarIdxW'(1);
          end
        end
      end
      ST_SP_RD: begin
        rd_addr = own_base + AddrW'(i_q);
      end
      ST_SP_CHK: begin
        d_d    = rd_data;
        keep_d = '0;
        v_d    = '0;
        if (!rd_single) begin
          rd_addr = other_base;
        end else if (!i_last) begin
          i_d = i_q + VarIdxW'(1);
        end else begin
          i_d = '0;
          if (!sup_side_q) begin
            sup_side_d = 1'b1;
          end else begin
            progress_d = 1'b0;
            k_d        = '0;
          end
        end
      end
      ST_SP_VCHK: begin
        // next read overlaps with the check of this one
        if (keep_hit) begin
          keep_d = keep_q | bit_v;
        end
        v_d     = v_q + VarIdxW'(1);
        rd_addr = other_base + AddrW'(v_q) + AddrW'(1);
      end
      ST_SP_WR: begin
        if (sup_chg) begin
          wr.en      = 1'b1;
          wr.addr    = own_base + AddrW'(i_q);
          wr.data    = keep_q;
          changed_d  = 1'b1;
          progress_d = 1'b1;
        end
        if (!sup_bad) begin
          if (!i_last) begin
            i_d = i_q + VarIdxW'(1);
          end else begin
            i_d = '0;
            if (!sup_side_q) begin
              sup_side_d = 1'b1;
            end else begin
              progress_d = 1'b0;
              k_d        = '0;
            end
          end
        end
      end
      ST_OUT_RD: begin
        rd_addr = k_q;
      end
      ST_OUT_EMIT: begin
        res_vld_d         = 1'b1;
        res_d.pruned_bits = rd_data;
        res_d.status      = changed_q ? StatChanged : StatUnchanged;
        res_d.last_result = k_last;
        k_d               = k_q + AddrW'(1);
        rd_addr           = k_q + AddrW'(1);
        if (k_last) begin
          load_cnt_d = '0;
          changed_d  = 1'b0;
        end
      end
      ST_CONTRA: begin
        res_vld_d         = 1'b1;
        res_d.pruned_bits = '0;
        res_d.status      = StatContra;
        res_d.last_result = 1'b1;
        load_cnt_d        = '0;
        changed_d         = 1'b0;
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      load_cnt_q <= '0;
      changed_q  <= 1'b0;
      progress_q <= 1'b0;
      n_q        <= VarW'(LimN);
      cfg_q      <= CfgW'(16);
      k_q        <= '0;
      i_q        <= '0;
      v_q        <= '0;
      fix_side_q <= 1'b0;
      sup_side_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      changed_q  <= changed_d;
      progress_q <= progress_d;
      n_q        <= n_d;
      k_q        <= k_d;
      i_q        <= i_d;
      v_q        <= v_d;
      fix_side_q <= fix_side_d;
      sup_side_q <= sup_side_d;
      res_vld_q  <= res_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    d_q    <= d_d;
    keep_q <= keep_d;
    tgt_q  <= tgt_d;
    res_q  <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // a result transfer only follows an emit or contradiction cycle
  `IPDP_ASSERT_IMPL(a_res_src, clk_i, rst_ni, result_valid_o,
    $past(state_q == ST_OUT_EMIT || state_q == ST_CONTRA), "result without emit state")
  // a contradiction is a single empty final item
  `IPDP_ASSERT_IMPL(a_contra_form, clk_i, rst_ni,
    result_valid_o && (result_o.status == StatContra),
    result_o.last_result && (result_o.pruned_bits == '0), "malformed contradiction item")
  // status is the same on every item of a run
  `IPDP_ASSERT_IMPL(a_status_steady, clk_i, rst_ni,
    result_valid_o && $past(result_valid_o) && !$past(result_o.last_result),
    result_o.status == $past(result_o.status), "status changed within a run")
  // the final domain always starts the run
  `IPDP_ASSERT(a_run_start, clk_i, rst_ni,
    (start_i && !busy_o && item_i.last_domain) |=> (state_q == ST_MASK_RD),
    "last domain did not start the run")

endmodule

/* dv/inverse_permutation_domain_presolve_checker.sv */
// result checker for the inverse permutation domain presolver
// keeps its own copy of the domain store and count register, predicts each run
// depends on ipdp_pkg for the transfer structs, status codes and sizes
module inverse_permutation_domain_presolve_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  ipdp_pkg::ipdp_in_t        item_i,
  input  logic                      result_valid_i,
  input  ipdp_pkg::ipdp_out_t       result_i,
  input  logic                      cfg_we_i,
  input  logic [ipdp_pkg::CfgW-1:0] cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        contra_o
);
  import ipdp_pkg::*;

  logic [ValueBits-1:0] domains [StoreDepth];
  int                   loaded;
  bit                   touched;
  bit                   progress;
  logic [CfgW-1:0]      count_reg;
  ipdp_out_t            expected_q [$];
  int                   fails;
  int                   checked;
  int                   contra;

  function automatic bit lone(logic [ValueBits-1:0] d);
    return (d != '0) && ((d & (d - ValueBits'(1))) == '0);
  endfunction

  function automatic int lowest_index(logic [ValueBits-1:0] d);
    for (int b = 0; b < ValueBits; b++) begin
      if (d[b]) return b;
    end
    return 0;
  endfunction

  // fix entry t to value index v, 0 on a clash or a missing value
  function automatic bit pin_value(int t, int v);
    logic [ValueBits-1:0] d;
    logic [ValueBits-1:0] b;
    d = domains[t];
    b = ValueBits'(1) << v;
    if (lone(d)) return d == b;
    if ((d & b) == '0) return 1'b0;
    domains[t] = b;
    touched    = 1'b1;
    progress   = 1'b1;
    return 1'b1;
  endfunction

  // keep value v of an unfixed own[i] only while other[v] still holds i
  function automatic bit prune_side(int n, int own, int other);
    logic [ValueBits-1:0] d;
    logic [ValueBits-1:0] keep;
    for (int i = 0; i < n; i++) begin
      d = domains[own + i];
      if (lone(d)) continue;
      keep = '0;
      for (int v = 0; v < n; v++) begin
        if (d[v] && domains[other + v][i]) keep[v] = 1'b1;
      end
      if (keep != d) begin
        domains[own + i] = keep;
        touched          = 1'b1;
        progress         = 1'b1;
      end
      if (keep == '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // drop high bits, then narrow to the fixed point; 0 on contradiction
  function automatic bit narrow(int n);
    logic [ValueBits-1:0] mask;
    mask = (n >= ValueBits) ? {ValueBits{1'b1}} : ValueBits'((1 << n) - 1);
    for (int k = 0; k < 2 * n; k++) begin
      if ((domains[k] & ~mask) != '0) touched = 1'b1;
      domains[k] = domains[k] & mask;
      if (domains[k] == '0) return 1'b0;
    end
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (lone(domains[i]) && !pin_value(n + lowest_index(domains[i]), i)) return 1'b0;
        if (lone(domains[n + i]) && !pin_value(lowest_index(domains[n + i]), i)) return 1'b0;
      end
      if (!prune_side(n, 0, n)) return 1'b0;
      if (!prune_side(n, n, 0)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_domain(ipdp_in_t d);
    int        n;
    ipdp_out_t e;
    n = (count_reg == '0) ? 1 : ((int'(count_reg) > LimN) ? LimN : int'(count_reg));
    if (loaded < 2 * n && loaded < StoreDepth) begin
      domains[loaded] = d.domain_bits;
      if (d.outside_values) touched = 1'b1;
      loaded++;
    end
    if (!d.last_domain) return;
    if (!narrow(n)) begin
      e.pruned_bits = '0;
      e.status      = StatContra;
      e.last_result = 1'b1;
      expected_q.insert(expected_q.size(), e);
      contra++;
    end else begin
      for (int k = 0; k < 2 * n; k++) begin
        e.pruned_bits = domains[k];
        e.status      = touched ? StatChanged : StatUnchanged;
        e.last_result = (k == 2 * n - 1);
        expected_q.insert(expected_q.size(), e);
      end
    end
    loaded  = 0;
    touched = 1'b0;
  endfunction

  function automatic void check_result(ipdp_out_t r);
    ipdp_out_t e;
    checked++;
    if (expected_q.size() == 0) begin
      if (fails < 10) begin
        $display("%0t: result bits %h status %0d last %0b with nothing expected",
                 $time, r.pruned_bits, r.status, r.last_result);
      end
      fails++;
      return;
    end
    e = expected_q.pop_front();
    if (r.pruned_bits !== e.pruned_bits || r.status !== e.status ||
        r.last_result !== e.last_result) begin
      if (fails < 10) begin
        $display("%0t: expected bits %h status %0d last %0b, got bits %h status %0d last %0b",
                 $time, e.pruned_bits, e.status, e.last_result,
                 r.pruned_bits, r.status, r.last_result);
      end
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < StoreDepth; k++) domains[k] = '0;
      loaded    = 0;
      touched   = 1'b0;
      count_reg = CfgW'(16);
      expected_q.delete();
      fails   = 0;
      checked = 0;
      contra  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      contra_o     <= 0;
    end else begin
      if (result_valid_i) check_result(result_i);
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (start_i && !busy_i) take_domain(item_i);
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
      checked_o    <= checked;
      contra_o     <= contra;
    end
  end

endmodule

/* dv/tb_inverse_permutation_domain_presolve_top.sv */
// testbench top for the inverse permutation domain presolver: drives data sets
// of domains and count settings, the checker beside the block judges results
// depends on ipdp_pkg, inverse_permutation_domain_presolve_checker and the rtl
module tb_inverse_permutation_domain_presolve_top;
  import ipdp_pkg::*;

  localparam int MaxGap       = 19;
  // results can come before the block drops busy
  localparam int SettleCycles = 2 * MaxVars + 4;
  // slowest legal run at n = 16: mask, then up to 2n*n+1 passes of fixing and
  // support pruning, then emit; taken about 3.3 times over
  localparam int WatchdogLimit = 1_200_000;

  typedef enum int {
    SetPermutation,  // consistent permutation plus random extra values
    SetNoise,        // fully random domains
    SetBroken,       // consistent, then one domain emptied or pinned at random
    SetOverfull,     // extra transfers past 2n that the block must not store
    SetEarly         // last domain before 2n, rest comes from the store
  } set_kind_e;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  ipdp_in_t         item;
  logic             result_valid;
  ipdp_out_t        result;
  logic             cfg_we;
  logic [CfgW-1:0]  cfg_wdata;

  int               fail_count;
  int               pending;
  int               checked;
  int               contra;

  ipdp_in_t         set_q [$];
  int               n_now;
  int               filled = 0;     // store positions written since reset
  int               transfers = 0;
  int               data_sets = 0;
  int               settings = 0;
  int               idle_cycles = 0;

  // count settings per phase and data sets per phase; 0 and 31 are out of range
  int phase_count [8] = '{3, 0, 4, 31, 1, 5, 16, 2};
  int phase_sets  [8] = '{3, 5, 2, 1, 4, 2, 1, 4};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  inverse_permutation_domain_presolve_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  inverse_permutation_domain_presolve_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .contra_o       (contra)
  );

  // watchdog: any stretch this long without a transfer or a result is a hang
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_inverse_permutation_domain_presolve_top NOT OK");
      $finish;
    end
  end

  // count register write, only ever issued while the block is idle
  task automatic write_count(int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= CfgW'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    // effective n, to size the data sets that follow
    n_now = (v == 0) ? 1 : ((v > LimN) ? LimN : v);
    settings++;
  endtask

  // wait until every expected result is in and the block is back to idle
  task automatic wait_drained();
    // the checker's pending count is registered, so it lags behind the last transfer
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic queue_domain(logic [ValueBits-1:0] bits, logic outside);
    ipdp_in_t d;
    d.domain_bits    = bits;
    d.outside_values = outside;
    d.last_domain    = 1'b0;
    set_q.insert(set_q.size(), d);
  endtask

  // random data set of the given kind for n variables per side
  task automatic build_set(int n, set_kind_e kind);
    int                   perm [MaxVars];
    int                   inv  [MaxVars];
    int                   j;
    int                   tmp;
    int                   pos;
    bit                   spill_on;
    logic [ValueBits-1:0] mask;
    logic [ValueBits-1:0] noise;
    logic [ValueBits-1:0] base;
    ipdp_in_t             d;
    set_q.delete();
    mask = (n >= ValueBits) ? {ValueBits{1'b1}} : ValueBits'((1 << n) - 1);
    // random permutation as the hidden solution
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < n; i++) inv[perm[i]] = i;
    // now and then also set bits above n, which the block must drop
    spill_on = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < 2 * n; k++) begin
      // density varies from dense to sparse
      noise = ValueBits'($urandom());
      if ($urandom_range(0, 1)) noise = noise & ValueBits'($urandom());
      if ($urandom_range(0, 1)) noise = noise & ValueBits'($urandom());
      base = (k < n) ? ValueBits'(1) << perm[k] : ValueBits'(1) << inv[k - n];
      if (kind == SetNoise) begin
        d.domain_bits = noise;
      end else begin
        d.domain_bits = base | (noise & mask) | (spill_on ? (noise & ~mask) : '0);
      end
      d.outside_values = ($urandom_range(0, 5) == 0);
      d.last_domain    = 1'b0;
      set_q.insert(set_q.size(), d);
    end
    case (kind)
      SetBroken: begin
        pos = $urandom_range(0, 2 * n - 1);
        d   = set_q[pos];
        d.domain_bits = $urandom_range(0, 1) ? '0 :
                        ValueBits'(1) << $urandom_range(0, n - 1);
        set_q[pos] = d;
      end
      SetOverfull: begin
        repeat ($urandom_range(1, 3)) begin
          queue_domain(ValueBits'($urandom()), 1'($urandom_range(0, 1)));
        end
      end
      SetEarly: begin
        // only once every position the run reads has been written
        if (filled >= 2 * n) begin
          pos = $urandom_range(1, 2 * n - 1);
          while (set_q.size() > pos) void'(set_q.pop_back());
        end
      end
      default: begin
      end
    endcase
  endtask

  // send the queued set, last domain flag on its final transfer
  task automatic send_set();
    int       gap [$];
    int       stored;
    bit       stretch;
    ipdp_in_t d;
    d = set_q[$];
    d.last_domain = 1'b1;
    set_q[$] = d;
    stored = (set_q.size() < 2 * n_now) ? set_q.size() : 2 * n_now;
    if (stored > filled) filled = stored;
    // a third of the sets go back to back, the rest with random gaps
    stretch = ($urandom_range(0, 2) == 0);
    foreach (set_q[k]) gap.insert(gap.size(), stretch ? 0 : $urandom_range(0, MaxGap));
    // start was lowered after the previous set, so never raise it in that step
    if (gap[0] == 0) gap[0] = 1;
    foreach (set_q[k]) begin
      if (gap[k] > 0) repeat (gap[k]) @(posedge clk);
      start <= 1'b1;
      item  <= set_q[k];
      do @(posedge clk); while (busy);
      // keep start high only if the next transfer follows at once
      if (k == set_q.size() - 1 || gap[k + 1] > 0) start <= 1'b0;
    end
    transfers += set_q.size();
    data_sets++;
    set_q.delete();
  endtask

  initial begin
    set_kind_e kind;
    int        r;
    rst_n     = 1'b0;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    n_now     = 16;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sets at n = 2
    write_count(2);
    // everything open, high bits and the outside flag set: changed, no pruning
    repeat (4) queue_domain(16'hFFFF, 1'b1);
    send_set();
    // empty domain
    queue_domain(16'h0000, 1'b0);
    repeat (3) queue_domain(16'h0003, 1'b0);
    send_set();
    // two forward variables fixed to the same value
    queue_domain(16'h0001, 1'b0);
    queue_domain(16'h0001, 1'b0);
    queue_domain(16'h0003, 1'b0);
    queue_domain(16'h0003, 1'b0);
    send_set();
    // one fixed value forces the whole permutation
    queue_domain(16'h0002, 1'b0);
    repeat (3) queue_domain(16'h0003, 1'b0);
    send_set();
    // already a consistent fixed permutation: unchanged
    queue_domain(16'h0001, 1'b0);
    queue_domain(16'h0002, 1'b0);
    queue_domain(16'h0001, 1'b0);
    queue_domain(16'h0002, 1'b0);
    send_set();
    // too many domains: the fifth transfer is not stored but starts the run
    repeat (4) queue_domain(16'h0003, 1'b0);
    queue_domain(16'hA5A5, 1'b0);
    send_set();
    // early last domain: the other three come from the store
    queue_domain(16'h0002, 1'b0);
    send_set();

    // random phases, one count setting each
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_count(phase_count[p]);
      for (int s = 0; s < phase_sets[p]; s++) begin
        r = $urandom_range(0, 9);
        kind = (r <= 5) ? SetPermutation :
               (r == 6) ? SetNoise :
               (r == 7) ? SetBroken :
               (r == 8) ? SetOverfull : SetEarly;
        build_set(n_now, kind);
        send_set();
        // sometimes hold off until the block has emptied out
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
    end
    wait_drained();

    $display("sent %0d domain transfers in %0d data sets under %0d count settings",
             transfers, data_sets, settings);
    $display("checked %0d results, %0d runs ended in a contradiction", checked, contra);
    if (fail_count == 0) begin
      $display("tb_inverse_permutation_domain_presolve_top OK");
    end else begin
      $display("tb_inverse_permutation_domain_presolve_top NOT OK");
    end
    $finish;
  end

endmodule
